### src/additive_lagged_random_generator_defines.svh
// Assertion macros for the additive lagged generator
`ifndef ADDITIVE_LAGGED_RANDOM_GENERATOR_DEFINES_SVH
`define ADDITIVE_LAGGED_RANDOM_GENERATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define ALRG_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define ALRG_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ALRG_ASSERT_IMP(label, ante, cons, msg)
`define ALRG_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

### src/alrg_pkg.sv
package alrg_pkg;

	localparam int WORD_BITS = 32;
	localparam int RESULT_BITS = 31;
	localparam int WARM_BITS = 8;
	localparam int RESET_TABLE_BITS = 5;

	localparam logic [WORD_BITS-1:0] LCG_MUL = 32'd1103515245;
	localparam logic [WORD_BITS-1:0] LCG_ADD = 32'd12345;

	localparam logic [WORD_BITS-1:0] RESET_WORDS [32] = '{
		32'h6fdb9cb7, 32'h9de8dc3d, 32'h093bf9e4, 32'h47528c2b,
		32'hfc263867, 32'h53cbf1bf, 32'h13618c92, 32'h9e0f31b1,
		32'hcd651ab0, 32'h2b52a7e5, 32'h2ccdd9bf, 32'h30052e2e,
		32'hb278be81, 32'hd634a58b, 32'h0a33d2c1, 32'hfd42f052,
		32'hcb2f06f8, 32'ha57bb730, 32'h4ca963ac, 32'h84bf5532,
		32'hd67ab9e6, 32'h6e2d017b, 32'h1e17cd99, 32'h5891173a,
		32'h39384a29, 32'he0a0282e, 32'h2e5512fc, 32'h3093f269,
		32'h3a6983e6, 32'h6b9fdaf3, 32'h38b6bbd1, 32'hb5e23046
	};

	typedef enum logic {
		ALU_DRAW,
		ALU_LCG
	} alu_op_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_CALC,
		ST_FILL,
		ST_WARM_RD,
		ST_WARM_CALC
	} alrg_state_t;

	typedef enum logic {
		ACT_SEED = 1'b0,
		ACT_DRAW = 1'b1
	} action_t;

endpackage

### src/additive_lagged_random_generator.sv
// channel | dir | tdata                      | tuser
// s       | in  | [31:0] seed_value (signed) | [0] action (0 seed, 1 draw)
// m       | out | [30:0] random_value, [31] 0 | -
//
// Draw: table read, then sum and write-back through the one adder.
// Seed: request, chain fill of TABLE_WORDS words, then hidden draws, each a table
// read and then a sum with write-back (up to about 770 draws).
// After reset an init pass writes all TABLE_WORDS table words, s_tready low.
// A draw holds in its sum cycle while the result register is still full.
`include "additive_lagged_random_generator_defines.svh"

module additive_lagged_random_generator
	import alrg_pkg::*;
#(
	parameter int TABLE_WORDS = 32,
	parameter int LAG_DISTANCE = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [31:0] seed_value
	input  logic        s_tuser,  // [0] action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata   // [30:0] random_value, [31] zero
);

	localparam int IW = (TABLE_WORDS > 1) ? $clog2(TABLE_WORDS) : 1;
	localparam int WR_RESET = LAG_DISTANCE % TABLE_WORDS;

	alrg_state_t state_q, state_d;

	logic [IW-1:0]          fill_cnt_q;
	logic [IW-1:0]          read_index_q;
	logic [IW-1:0]          write_index_q;
	logic [WORD_BITS-1:0]   seed_q;
	logic [WARM_BITS-1:0]   warm_cnt_q;
	logic                   phase2_q;
	logic                   extra_q;
	logic                   out_valid_q;
	logic [RESULT_BITS-1:0] out_data_q;

	logic                 req;
	logic                 draw_go;
	logic                 fill_last;
	logic                 warm_more;
	logic [WARM_BITS-1:0] warm_val;

	logic                 tbl_we;
	logic [IW-1:0]        tbl_waddr;
	logic [WORD_BITS-1:0] tbl_wdata;
	logic                 tbl_re;
	logic [WORD_BITS-1:0] rd_a;
	logic [WORD_BITS-1:0] rd_b;

	alu_op_t              alu_op;
	logic [WORD_BITS-1:0] alu_a;
	logic [WORD_BITS-1:0] alu_y;

	function automatic logic [IW-1:0] next_idx(input logic [IW-1:0] idx);
		return (idx == IW'(TABLE_WORDS - 1)) ? '0 : idx + 1'b1;
	endfunction

	assign s_tready = (state_q == ST_IDLE);
	assign req = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata = {1'b0, out_data_q};

	assign draw_go = (state_q == ST_CALC) && (!out_valid_q || m_tready);
	assign fill_last = (fill_cnt_q == IW'(TABLE_WORDS - 1));
	assign warm_val = alu_y[WARM_BITS:1] ^ seed_q[WARM_BITS-1:0];
	assign warm_more = (warm_cnt_q < warm_val);

	assign alu_op = (state_q == ST_FILL) ? ALU_LCG : ALU_DRAW;
	assign alu_a = (state_q == ST_FILL) ? seed_q : rd_a;

	alrg_alu u_alu (
		.op (alu_op),
		.a  (alu_a),
		.b  (rd_b),
		.y  (alu_y)
	);

	alrg_table #(
		.DEPTH (TABLE_WORDS),
		.AW    (IW)
	) u_table (
		.clk     (clk),
		.we      (tbl_we),
		.waddr   (tbl_waddr),
		.wdata   (tbl_wdata),
		.re      (tbl_re),
		.raddr_a (read_index_q),
		.raddr_b (write_index_q),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	always_comb begin
		state_d = state_q;
		tbl_we = 1'b0;
		tbl_re = 1'b0;
		tbl_waddr = write_index_q;
		tbl_wdata = alu_y;
		case (state_q)
			ST_INIT: begin
				tbl_we = 1'b1;
				tbl_waddr = fill_cnt_q;
				tbl_wdata = RESET_WORDS[RESET_TABLE_BITS'(fill_cnt_q)];
				if (fill_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (req) begin
					if (s_tuser == ACT_DRAW) begin
						tbl_re = 1'b1;
						state_d = ST_CALC;
					end else begin
						state_d = ST_FILL;
					end
				end
			end
			ST_CALC: begin
				if (draw_go) begin
					tbl_we = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_FILL: begin
				tbl_we = 1'b1;
				tbl_waddr = fill_cnt_q;
				if (fill_last) begin
					state_d = ST_WARM_RD;
				end
			end
			ST_WARM_RD: begin
				tbl_re = 1'b1;
				state_d = ST_WARM_CALC;
			end
			ST_WARM_CALC: begin
				tbl_we = 1'b1;
				if (phase2_q && !extra_q && !warm_more) begin
					state_d = ST_IDLE;
				end else begin
					state_d = ST_WARM_RD;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			fill_cnt_q <= '0;
			read_index_q <= '0;
			write_index_q <= IW'(WR_RESET);
			warm_cnt_q <= '0;
			phase2_q <= 1'b0;
			extra_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_INIT || state_q == ST_FILL) begin
				fill_cnt_q <= fill_last ? '0 : fill_cnt_q + 1'b1;
			end
			if (state_q == ST_FILL && fill_last) begin
				read_index_q <= '0;
				write_index_q <= IW'(WR_RESET);
				warm_cnt_q <= '0;
				phase2_q <= 1'b0;
				extra_q <= 1'b0;
			end
			if (draw_go || state_q == ST_WARM_CALC) begin
				read_index_q <= next_idx(read_index_q);
				write_index_q <= next_idx(write_index_q);
			end
			if (state_q == ST_WARM_CALC) begin
				if (!phase2_q) begin
					if (warm_more) begin
						warm_cnt_q <= warm_cnt_q + 1'b1;
					end else begin
						warm_cnt_q <= '0;
						phase2_q <= 1'b1;
					end
				end else if (extra_q) begin
					extra_q <= 1'b0;
					warm_cnt_q <= warm_cnt_q + 1'b1;
				end else if (warm_more) begin
					extra_q <= 1'b1;
				end
			end
			if (draw_go) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req && s_tuser == ACT_SEED) begin
			seed_q <= s_tdata;
		end else if (state_q == ST_FILL) begin
			seed_q <= alu_y;
		end
		if (draw_go) begin
			out_data_q <= alu_y[WORD_BITS-1:1];
		end
	end

	// index pair must stay the lag apart, modulo the table size
	logic [IW:0]   lag_sum;
	logic [IW-1:0] lag_exp;

	always_comb begin
		lag_sum = {1'b0, read_index_q} + (IW+1)'(WR_RESET);
		if (lag_sum >= (IW+1)'(TABLE_WORDS)) begin
			lag_exp = IW'(lag_sum - (IW+1)'(TABLE_WORDS));
		end else begin
			lag_exp = IW'(lag_sum);
		end
	end

	`ALRG_ASSERT_IMP(a_lag_kept, state_q != ST_INIT, write_index_q == lag_exp, "index lag lost")
	`ALRG_ASSERT_NXT(a_busy_after_req, req, !s_tready, "ready right after a request")
	`ALRG_ASSERT_NXT(a_result_after_draw, draw_go, m_tvalid, "draw gave no result")

endmodule

### src/alrg_table.sv
module alrg_table
	import alrg_pkg::*;
#(
	parameter int DEPTH = 32,
	parameter int AW = 5
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [AW-1:0]        waddr,
	input  logic [WORD_BITS-1:0] wdata,
	input  logic                 re,
	input  logic [AW-1:0]        raddr_a,
	input  logic [AW-1:0]        raddr_b,
	output logic [WORD_BITS-1:0] rdata_a,
	output logic [WORD_BITS-1:0] rdata_b
);

	logic [WORD_BITS-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

### src/alrg_alu.sv
module alrg_alu
	import alrg_pkg::*;
(
	input  alu_op_t              op,
	input  logic [WORD_BITS-1:0] a,
	input  logic [WORD_BITS-1:0] b,
	output logic [WORD_BITS-1:0] y
);

	logic [WORD_BITS-1:0] a_adj;
	logic [2*WORD_BITS-1:0] prod;

	always_comb begin
		a_adj = (a[WORD_BITS-1] && b[WORD_BITS-1]) ? (~a + 1'b1) : a;
		prod = a * LCG_MUL;
		case (op)
			ALU_DRAW: y = a_adj + b;
			ALU_LCG:  y = prod[WORD_BITS-1:0] + LCG_ADD;
			default:  y = a_adj + b;
		endcase
	end

endmodule

### bench/tb_additive_lagged_random_generator.sv
module tb_additive_lagged_random_generator
	import alrg_pkg::*;
();

	localparam int TABLE_WORDS = 32;
	localparam int LAG_DISTANCE = 3;
	localparam int CYCLE_LIMIT = 6000000;
	localparam int DRAIN_CYCLES = 2000;
	localparam int RANDOM_ITEMS = 700;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;  // [31:0] seed_value
	logic        s_tuser;  // [0] action
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;  // [30:0] random_value, [31] zero

	additive_lagged_random_generator #(
		.TABLE_WORDS(TABLE_WORDS),
		.LAG_DISTANCE(LAG_DISTANCE)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	logic [31:0] gen_table [TABLE_WORDS];
	int unsigned lag_rd;
	int unsigned lag_wr;
	logic [30:0] pending_values [$];

	int unsigned errors;
	int unsigned cycle_count;
	int unsigned draws_sent;
	int unsigned seeds_sent;
	int unsigned values_checked;
	bit no_idle;
	bit no_stall;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	function automatic logic [30:0] next_value();
		logic [31:0] first;
		logic [31:0] second;
		logic [31:0] sum;
		first = gen_table[lag_rd];
		second = gen_table[lag_wr];
		if (first[31] && second[31]) begin
			first = 32'd0 - first;
		end
		sum = first + second;
		gen_table[lag_wr] = sum;
		lag_rd = (lag_rd + 1 >= TABLE_WORDS) ? 0 : lag_rd + 1;
		lag_wr = (lag_wr + 1 >= TABLE_WORDS) ? 0 : lag_wr + 1;
		return sum[31:1];
	endfunction

	function automatic int unsigned warm_limit(logic [31:0] chain);
		logic [31:0] mixed;
		mixed = {1'b0, next_value()} ^ chain;
		return int'(mixed[7:0]);
	endfunction

	function automatic void reseed_model(logic [31:0] seed);
		logic [31:0] chain;
		int unsigned count;
		chain = seed;
		for (int n = 0; n < TABLE_WORDS; n++) begin
			chain = chain * LCG_MUL + LCG_ADD;
			gen_table[n] = chain;
		end
		lag_rd = 0;
		lag_wr = LAG_DISTANCE % TABLE_WORDS;
		count = 0;
		while (count < warm_limit(chain)) begin
			count++;
		end
		count = 0;
		while (count < warm_limit(chain)) begin
			void'(next_value());
			count++;
		end
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %08h expected %08h at cycle %0d",
			what, got, want, cycle_count);
		errors++;
	endtask

	task automatic send_request(action_t act, logic [31:0] seed);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= (act == ACT_SEED) ? seed : $urandom;
		do @(posedge clk); while (!s_tready);
		if (act == ACT_SEED) begin
			reseed_model(seed);
			seeds_sent++;
		end else begin
			pending_values.push_back(next_value());
			draws_sent++;
		end
	endtask

	// receiver with random backpressure
	initial begin
		int stall;
		m_tready <= 1'b0;
		@(posedge clk);
		forever begin
			stall = no_stall ? 0 : $urandom_range(0, 6);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_values.size() == 0) begin
				report_mismatch("unexpected result", m_tdata, 32'd0);
			end else begin
				if (m_tdata !== {1'b0, pending_values[0]}) begin
					report_mismatch("random_value", m_tdata, {1'b0, pending_values[0]});
				end
				void'(pending_values.pop_front());
				values_checked++;
			end
		end
	end

	task automatic test_reset_table_draws();
		// reset table: first draws include the both-negative negation path
		for (int i = 0; i < 6; i++) begin
			send_request(ACT_DRAW, 32'd0);
		end
	endtask

	task automatic test_seed_extremes();
		logic [31:0] seeds [5];
		seeds = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff,
			32'h0000_0001};
		foreach (seeds[i]) begin
			send_request(ACT_SEED, seeds[i]);
			send_request(ACT_DRAW, 32'd0);
			send_request(ACT_DRAW, 32'd0);
		end
	endtask

	task automatic test_back_to_back_seeds();
		no_idle = 1'b1;
		send_request(ACT_SEED, 32'h1234_5678);
		send_request(ACT_SEED, 32'hedcb_a987);
		send_request(ACT_DRAW, 32'd0);
		send_request(ACT_DRAW, 32'd0);
		no_idle = 1'b0;
	endtask

	task automatic test_random_mix();
		logic [31:0] seed;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 100 == 0) begin
				no_idle = ($urandom_range(0, 3) == 0);
				no_stall = ($urandom_range(0, 3) == 0);
			end
			if ($urandom_range(0, 15) == 0) begin
				case ($urandom_range(0, 7))
					0: seed = 32'h8000_0000;
					1: seed = 32'h7fff_ffff;
					2: seed = 32'hffff_ffff;
					default: seed = $urandom;
				endcase
				send_request(ACT_SEED, seed);
			end else begin
				send_request(ACT_DRAW, 32'd0);
			end
		end
		no_idle = 1'b0;
		no_stall = 1'b0;
	endtask

	initial begin
		while (cycle_count < CYCLE_LIMIT) @(posedge clk);
		$display("timeout after %0d cycles", cycle_count);
		$display("** additive_lagged_random_generator: FAILED **");
		$finish;
	end

	initial begin
		errors = 0;
		draws_sent = 0;
		seeds_sent = 0;
		values_checked = 0;
		no_idle = 1'b0;
		no_stall = 1'b0;
		for (int n = 0; n < TABLE_WORDS; n++) begin
			gen_table[n] = RESET_WORDS[n % 32];
		end
		lag_rd = 0;
		lag_wr = LAG_DISTANCE % TABLE_WORDS;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= 32'd0;
		s_tuser <= ACT_DRAW;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		test_reset_table_draws();
		test_seed_extremes();
		test_back_to_back_seeds();
		test_random_mix();
		s_tvalid <= 1'b0;

		while (pending_values.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d draw requests and %0d seed requests, %0d values checked",
			draws_sent, seeds_sent, values_checked);
		$display("seeds covered sign and all-ones/zero extremes; mismatches: %0d", errors);
		if (errors == 0) begin
			$display("** additive_lagged_random_generator: PASSED **");
		end else begin
			$display("** additive_lagged_random_generator: FAILED **");
		end
		$finish;
	end

endmodule
